@@ rtl/pbt_pkg.sv @@
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the paged block table
// Operation, status and register codes, configuration and entry records, and
// the state types of the controller and of the block index divider.
// ----------------------------------------------------------------------------
package pbt_pkg;

  // Default sizes of the stores.
  localparam int MAX_HEADS_DEF   = 32;
  localparam int BLOCK_SLOTS_DEF = 256;

  // Field widths fixed by the interface.
  localparam int LEN_W  = 24;
  localparam int TPB_W  = 16;
  localparam int BPH_W  = 9;
  localparam int HIU_W  = 6;
  localparam int VLEN_W = 11;
  localparam int FMT_W  = 4;
  localparam int RC_W   = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Longest sequence a head may hold.
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  // Reference count ceiling.
  localparam logic [RC_W-1:0]  RC_MAX  = '1;

  // Reset values of the configuration registers.
  localparam logic [TPB_W-1:0]  TPB_RESET  = 16'd16;
  localparam logic [BPH_W-1:0]  BPH_RESET  = 9'd256;
  localparam logic [HIU_W-1:0]  HIU_RESET  = 6'd32;
  localparam logic [VLEN_W-1:0] VLEN_RESET = 11'd128;
  localparam logic [FMT_W-1:0]  FMT_RESET  = 4'd0;

  typedef enum logic [2:0] {
    OP_APPEND      = 3'd0,
    OP_SHARE       = 3'd1,
    OP_FREE        = 3'd2,
    OP_READ_ENTRY  = 3'd3,
    OP_READ_LENGTH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD       = 2'd1,
    STAT_NO_BLOCKS = 2'd2,
    STAT_ABSENT    = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TOKENS_PER_BLOCK = 3'd0,
    CFG_BLOCKS_PER_HEAD  = 3'd1,
    CFG_HEADS_IN_USE     = 3'd2,
    CFG_VECTOR_LENGTH    = 3'd3,
    CFG_KEY_FORMAT       = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [TPB_W-1:0]  tokens_per_block;
    logic [BPH_W-1:0]  blocks_per_head;
    logic [HIU_W-1:0]  heads_in_use;
    logic [VLEN_W-1:0] vector_length_expected;
    logic [FMT_W-1:0]  key_format;
  } cfg_t;

  // One word of the entry store.
  typedef struct packed {
    logic [RC_W-1:0]  use_cnt;
    logic             value_valid;
    logic [FMT_W-1:0] fmt;
  } entry_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       block_used;
    logic             key_allocated;
    logic             copied_on_write;
    logic             value_allocated;
    logic [RC_W-1:0]  reference_count;
    logic             key_block_present;
    logic             value_block_present;
    logic [FMT_W-1:0] stored_format;
    logic [LEN_W-1:0] sequence_length;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_DIV,
    S_ENTRY
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN
  } div_state_t;

endpackage

@@ rtl/pbt_cfg.sv @@
// ----------------------------------------------------------------------------
// pbt_cfg: configuration register file
// Holds the five configuration registers and takes one write transaction per
// cycle; writes to indices beyond the list are dropped.
// ----------------------------------------------------------------------------
module pbt_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pbt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pbt_pkg::cfg_t                    cfg
);

  pbt_pkg::cfg_t cfg_r;
  pbt_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Decode the register index of a write transaction.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        pbt_pkg::CFG_TOKENS_PER_BLOCK: begin
          cfg_nxt.tokens_per_block = cfg_data[pbt_pkg::TPB_W-1:0];
        end
        pbt_pkg::CFG_BLOCKS_PER_HEAD: begin
          cfg_nxt.blocks_per_head = cfg_data[pbt_pkg::BPH_W-1:0];
        end
        pbt_pkg::CFG_HEADS_IN_USE: begin
          cfg_nxt.heads_in_use = cfg_data[pbt_pkg::HIU_W-1:0];
        end
        pbt_pkg::CFG_VECTOR_LENGTH: begin
          cfg_nxt.vector_length_expected = cfg_data[pbt_pkg::VLEN_W-1:0];
        end
        pbt_pkg::CFG_KEY_FORMAT: begin
          cfg_nxt.key_format = cfg_data[pbt_pkg::FMT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  // Register file with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tokens_per_block       <= pbt_pkg::TPB_RESET;
      cfg_r.blocks_per_head        <= pbt_pkg::BPH_RESET;
      cfg_r.heads_in_use           <= pbt_pkg::HIU_RESET;
      cfg_r.vector_length_expected <= pbt_pkg::VLEN_RESET;
      cfg_r.key_format             <= pbt_pkg::FMT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/pbt_div.sv @@
// ----------------------------------------------------------------------------
// pbt_div: block index divider
// Checks a head's length against the block limit times the block size and,
// when it is in range, works out length / tokens_per_block one quotient bit
// per cycle by restoring division.
// ----------------------------------------------------------------------------
module pbt_div #(
  parameter int BLOCK_SLOTS = pbt_pkg::BLOCK_SLOTS_DEF,
  localparam int BW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pbt_pkg::LEN_W-1:0]    length,
  input  logic [pbt_pkg::TPB_W-1:0]    tokens_per_block,
  input  logic [pbt_pkg::BPH_W-1:0]    blocks_per_head,
  output logic                         done,
  output logic                         out_of_blocks,
  output logic [BW-1:0]                quotient
);

  localparam int SW    = (BW > 1) ? $clog2(BW) : 1;
  localparam int DW    = pbt_pkg::TPB_W + BW;
  localparam int LIM_W = $clog2(BLOCK_SLOTS + 1);
  localparam int PW    = LIM_W + pbt_pkg::TPB_W;

  pbt_pkg::div_state_t div_state_r, div_state_nxt;

  logic [pbt_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]             dvs_r, dvs_nxt;
  logic [BW-1:0]             quot_r, quot_nxt;
  logic [SW-1:0]             step_r, step_nxt;
  logic [pbt_pkg::TPB_W-1:0] tpb_r, tpb_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic                      oob_r, oob_nxt;
  logic                      done_r, done_nxt;

  logic [pbt_pkg::TPB_W-1:0] tpb_eff;
  logic [LIM_W-1:0]          blim;

  // A block size of zero behaves as one; the block limit is capped by the store.
  assign tpb_eff = (tokens_per_block == '0) ? pbt_pkg::TPB_W'(1) : tokens_per_block;
  assign blim    = (32'(blocks_per_head) < BLOCK_SLOTS) ? LIM_W'(blocks_per_head)
                                                        : LIM_W'(BLOCK_SLOTS);

  assign done          = done_r;
  assign out_of_blocks = oob_r;
  assign quotient      = quot_r;

  // Next state and datapath of the divider.
  always_comb begin
    div_state_nxt = div_state_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    tpb_nxt       = tpb_r;
    prod_nxt      = prod_r;
    oob_nxt       = oob_r;
    done_nxt      = 1'b0;
    case (div_state_r)
      pbt_pkg::DIV_IDLE: begin
        if (start) begin
          rem_nxt       = length;
          tpb_nxt       = tpb_eff;
          prod_nxt      = PW'(blim) * PW'(tpb_eff);
          quot_nxt      = '0;
          div_state_nxt = pbt_pkg::DIV_CHECK;
        end
      end
      pbt_pkg::DIV_CHECK: begin
        if ((32'(rem_r) >= 32'(prod_r)) || (rem_r == pbt_pkg::LEN_MAX)) begin
          oob_nxt       = 1'b1;
          done_nxt      = 1'b1;
          div_state_nxt = pbt_pkg::DIV_IDLE;
        end else begin
          oob_nxt       = 1'b0;
          dvs_nxt       = DW'(tpb_r) << (BW - 1);
          step_nxt      = SW'(BW - 1);
          div_state_nxt = pbt_pkg::DIV_RUN;
        end
      end
      pbt_pkg::DIV_RUN: begin
        if (32'(rem_r) >= 32'(dvs_r)) begin
          rem_nxt  = rem_r - pbt_pkg::LEN_W'(dvs_r);
          quot_nxt = (quot_r << 1) | BW'(1);
        end else begin
          quot_nxt = quot_r << 1;
        end
        dvs_nxt  = dvs_r >> 1;
        step_nxt = step_r - SW'(1);
        if (step_r == '0) begin
          done_nxt      = 1'b1;
          div_state_nxt = pbt_pkg::DIV_IDLE;
        end
      end
      default: begin
        div_state_nxt = pbt_pkg::DIV_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= pbt_pkg::DIV_IDLE;
      done_r      <= 1'b0;
    end else begin
      div_state_r <= div_state_nxt;
      done_r      <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
    tpb_r  <= tpb_nxt;
    prod_r <= prod_nxt;
    oob_r  <= oob_nxt;
  end

endmodule

@@ rtl/paged_block_table_refcount.sv @@
// ----------------------------------------------------------------------------
// paged_block_table_refcount: block table of a paged key/value cache
// Keeps per-head lengths and block counts and per-entry reference counts,
// value marks and formats in two synchronous memories, and serves append,
// share, free and read commands by read, modify and write back.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  -------   -------------------   ---------------------------------------------
//  command   start & !busy         in_op, in_head_index, in_block_index,
//                                  in_value_present, in_vector_length
//  result    out_valid (1 cycle)   out_status ... out_sequence_length
//  config    cfg_valid & cfg_ready cfg_index, cfg_data
//
//  A command holds busy through S_HEAD only on a bad head, an unknown op, a read of length,
//  an append of the wrong dimension or a block beyond those in use; other share, free
//  and read entry commands go on to S_ENTRY; an append waits in S_DIV for its block
//  index from the one-bit-per-cycle block index divider and is answered there if it runs out
//  of blocks, else it goes on to the entry memory read in S_ENTRY.
//  out_valid rises at the clock edge at which busy falls and lasts one cycle.
//  After reset a clearing pass writes every entry, one per cycle, over an entry store of
//  MAX_HEADS * BLOCK_SLOTS entries rounded up to powers of two (8192 at the defaults);
//  busy stays high meanwhile and configuration writes are taken as usual.
//  The receiver takes every result; there is no back-pressure on results.
// ----------------------------------------------------------------------------
module paged_block_table_refcount #(
  parameter int MAX_HEADS   = pbt_pkg::MAX_HEADS_DEF,
  parameter int BLOCK_SLOTS = pbt_pkg::BLOCK_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_op,
  input  logic [4:0]                       in_head_index,
  input  logic [7:0]                       in_block_index,
  input  logic                             in_value_present,
  input  logic [10:0]                      in_vector_length,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_block_used,
  output logic                             out_key_allocated,
  output logic                             out_copied_on_write,
  output logic                             out_value_allocated,
  output logic [7:0]                       out_reference_count,
  output logic                             out_key_block_present,
  output logic                             out_value_block_present,
  output logic [3:0]                       out_stored_format,
  output logic [23:0]                      out_sequence_length,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pbt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pbt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int HW          = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int BW          = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int BUW         = $clog2(BLOCK_SLOTS + 1);
  localparam int EAW         = HW + BW;
  localparam int ENTRY_DEPTH = 1 << EAW;
  localparam int HWW         = pbt_pkg::LEN_W + BUW;

  pbt_pkg::cfg_t        cfg;
  pbt_pkg::ctrl_state_t state_r, state_nxt;

  // Accepted command.
  logic [2:0]                 op_r;
  logic [4:0]                 head_r;
  logic [7:0]                 blk_r;
  logic                       want_r;
  logic [10:0]                vlen_r;
  logic                       accept;

  logic [EAW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic [HW-1:0]              head_a;
  logic [BW-1:0]              blk_a;
  logic                       head_ok;
  logic                       blk_bad;

  // Head memory: length and blocks in use.
  logic [HWW-1:0]             head_mem [MAX_HEADS];
  logic [HWW-1:0]             hd_rd_r;
  logic [HW-1:0]              hd_ra;
  logic                       hd_we;
  logic [HW-1:0]              hd_wa;
  logic [HWW-1:0]             hd_wd;
  logic [pbt_pkg::LEN_W-1:0]  hd_len;
  logic [BUW-1:0]             hd_biu;
  logic [BUW-1:0]             biu_new;

  // Entry memory.
  pbt_pkg::entry_t            ent_mem [ENTRY_DEPTH];
  pbt_pkg::entry_t            ent_rd_r;
  pbt_pkg::entry_t            ent_wd;
  pbt_pkg::entry_t            e_new;
  logic                       ent_re;
  logic [EAW-1:0]             ent_ra;
  logic [EAW-1:0]             ent_addr_r, ent_addr_nxt;
  logic                       ent_we;
  logic [EAW-1:0]             ent_wa;
  logic                       key_alloc;
  logic                       val_alloc;

  // Divider handshake.
  logic                       div_start;
  logic                       div_done;
  logic                       div_oob;
  logic [BW-1:0]              div_quot;

  // Result.
  pbt_pkg::res_t              res_r, res_nxt;
  logic                       out_valid_r;
  logic                       emit;

  pbt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbt_div #(
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_div (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (div_start),
    .length           (hd_len),
    .tokens_per_block (cfg.tokens_per_block),
    .blocks_per_head  (cfg.blocks_per_head),
    .done             (div_done),
    .out_of_blocks    (div_oob),
    .quotient         (div_quot)
  );

  assign busy   = (state_r != pbt_pkg::S_IDLE);
  assign accept = start && (state_r == pbt_pkg::S_IDLE);

  assign hd_ra   = HW'(in_head_index);
  assign head_a  = HW'(head_r);
  assign blk_a   = BW'(blk_r);
  assign hd_len  = hd_rd_r[HWW-1 -: pbt_pkg::LEN_W];
  assign hd_biu  = hd_rd_r[BUW-1:0];
  assign head_ok = (32'(head_r) < 32'(cfg.heads_in_use)) && (32'(head_r) < MAX_HEADS);
  assign blk_bad = (16'(blk_r) >= 16'(hd_biu)) || (32'(blk_r) >= BLOCK_SLOTS);

  // Controller: next state, memory accesses and the result.
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    hd_we        = 1'b0;
    hd_wa        = head_a;
    hd_wd        = hd_rd_r;
    ent_re       = 1'b0;
    ent_ra       = {head_a, blk_a};
    ent_addr_nxt = ent_addr_r;
    ent_we       = 1'b0;
    ent_wa       = ent_addr_r;
    ent_wd       = ent_rd_r;
    e_new        = ent_rd_r;
    key_alloc    = 1'b0;
    val_alloc    = 1'b0;
    biu_new      = hd_biu;
    div_start    = 1'b0;
    emit         = 1'b0;
    res_nxt      = '0;
    res_nxt.block_used = blk_r;

    case (state_r)
      // Zero every entry, and the heads on the way.
      pbt_pkg::S_CLEAR: begin
        ent_we      = 1'b1;
        ent_wa      = clr_cnt_r;
        ent_wd      = '0;
        if (32'(clr_cnt_r) < MAX_HEADS) begin
          hd_we = 1'b1;
          hd_wa = HW'(clr_cnt_r);
          hd_wd = '0;
        end
        clr_cnt_nxt = clr_cnt_r + EAW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = pbt_pkg::S_IDLE;
        end
      end

      pbt_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = pbt_pkg::S_HEAD;
        end
      end

      // Head is in; check the command, answer it or start the divider or entry read.
      pbt_pkg::S_HEAD: begin
        if (!head_ok) begin
          res_nxt.status = pbt_pkg::STAT_BAD;
          emit           = 1'b1;
          state_nxt      = pbt_pkg::S_IDLE;
        end else begin
          res_nxt.sequence_length = hd_len;
          case (op_r)
            pbt_pkg::OP_READ_LENGTH: begin
              emit      = 1'b1;
              state_nxt = pbt_pkg::S_IDLE;
            end
            pbt_pkg::OP_APPEND: begin
              if (vlen_r != cfg.vector_length_expected) begin
                res_nxt.status = pbt_pkg::STAT_BAD;
                emit           = 1'b1;
                state_nxt      = pbt_pkg::S_IDLE;
              end else begin
                div_start = 1'b1;
                state_nxt = pbt_pkg::S_DIV;
              end
            end
            pbt_pkg::OP_SHARE, pbt_pkg::OP_FREE, pbt_pkg::OP_READ_ENTRY: begin
              if (blk_bad) begin
                res_nxt.status = pbt_pkg::STAT_BAD;
                emit           = 1'b1;
                state_nxt      = pbt_pkg::S_IDLE;
              end else begin
                ent_re       = 1'b1;
                ent_addr_nxt = ent_ra;
                state_nxt    = pbt_pkg::S_ENTRY;
              end
            end
            default: begin
              res_nxt.status          = pbt_pkg::STAT_BAD;
              res_nxt.sequence_length = '0;
              emit                    = 1'b1;
              state_nxt               = pbt_pkg::S_IDLE;
            end
          endcase
        end
      end

      // Wait for the block index of an append.
      pbt_pkg::S_DIV: begin
        if (div_done) begin
          if (div_oob) begin
            res_nxt.status          = pbt_pkg::STAT_NO_BLOCKS;
            res_nxt.sequence_length = hd_len;
            emit                    = 1'b1;
            state_nxt               = pbt_pkg::S_IDLE;
          end else begin
            ent_re       = 1'b1;
            ent_ra       = {head_a, div_quot};
            ent_addr_nxt = {head_a, div_quot};
            state_nxt    = pbt_pkg::S_ENTRY;
          end
        end
      end

      // Entry is in: modify, write back and report.
      pbt_pkg::S_ENTRY: begin
        res_nxt.sequence_length = hd_len;
        case (op_r)
          pbt_pkg::OP_APPEND: begin
            // Any append leaves the block private to this head.
            key_alloc         = (ent_rd_r.use_cnt == '0);
            val_alloc         = want_r && !ent_rd_r.value_valid;
            e_new.use_cnt     = pbt_pkg::RC_W'(1);
            e_new.value_valid = ent_rd_r.value_valid || want_r;
            if (key_alloc) begin
              e_new.fmt = cfg.key_format;
              biu_new   = BUW'(div_quot) + BUW'(1);
            end
            hd_we = 1'b1;
            hd_wd = {hd_len + pbt_pkg::LEN_W'(1), biu_new};
            res_nxt.block_used      = 8'(div_quot);
            res_nxt.key_allocated   = key_alloc;
            res_nxt.copied_on_write = (ent_rd_r.use_cnt > pbt_pkg::RC_W'(1));
            res_nxt.value_allocated = val_alloc;
            res_nxt.sequence_length = hd_len + pbt_pkg::LEN_W'(1);
          end
          pbt_pkg::OP_SHARE: begin
            if (ent_rd_r.use_cnt == '0) begin
              res_nxt.status = pbt_pkg::STAT_ABSENT;
            end else if (ent_rd_r.use_cnt != pbt_pkg::RC_MAX) begin
              e_new.use_cnt = ent_rd_r.use_cnt + pbt_pkg::RC_W'(1);
            end
          end
          pbt_pkg::OP_FREE: begin
            if (ent_rd_r.use_cnt != '0) begin
              e_new.use_cnt = ent_rd_r.use_cnt - pbt_pkg::RC_W'(1);
            end
          end
          default: begin
            e_new = ent_rd_r;
          end
        endcase
        ent_we = 1'b1;
        ent_wd = e_new;
        res_nxt.reference_count     = e_new.use_cnt;
        res_nxt.key_block_present   = (e_new.use_cnt != '0);
        res_nxt.value_block_present = e_new.value_valid;
        res_nxt.stored_format       = e_new.fmt;
        emit                        = 1'b1;
        state_nxt                   = pbt_pkg::S_IDLE;
      end

      default: begin
        state_nxt = pbt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbt_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= emit;
    end
  end

  // Command capture, entry address and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      head_r <= in_head_index;
      blk_r  <= in_block_index;
      want_r <= in_value_present;
      vlen_r <= in_vector_length;
    end
    ent_addr_r <= ent_addr_nxt;
    if (emit) begin
      res_r <= res_nxt;
    end
  end

  // Head memory, read when a command is taken.
  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_wa] <= hd_wd;
    end
    if (accept) begin
      hd_rd_r <= head_mem[hd_ra];
    end
  end

  // Entry memory.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_ra];
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = res_r.status;
  assign out_block_used          = res_r.block_used;
  assign out_key_allocated       = res_r.key_allocated;
  assign out_copied_on_write     = res_r.copied_on_write;
  assign out_value_allocated     = res_r.value_allocated;
  assign out_reference_count     = res_r.reference_count;
  assign out_key_block_present   = res_r.key_block_present;
  assign out_value_block_present = res_r.value_block_present;
  assign out_stored_format       = res_r.stored_format;
  assign out_sequence_length     = res_r.sequence_length;

endmodule

@@ rtl/pbt_checker.sv @@
// ----------------------------------------------------------------------------
// pbt_checker: port level checks of the block table
// Watches the top level's ports for the clearing pass after reset, the
// command handshake and the consistency of reported append events.
// ----------------------------------------------------------------------------
module pbt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic [1:0]                       out_status,
  input logic                             out_key_allocated,
  input logic                             out_copied_on_write,
  input logic                             out_value_allocated,
  input logic [7:0]                       out_reference_count,
  input logic                             out_key_block_present
);

  // The clearing pass keeps the block busy straight after reset.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("block not busy after reset");

  // A command transaction makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  // A result only follows a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

  // A fresh key block is private, present and reported as a success.
  a_alloc_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_key_allocated) |->
      (out_reference_count == 8'd1) && out_key_block_present &&
      !out_copied_on_write && (out_status == pbt_pkg::STAT_OK))
    else $error("inconsistent key allocation");

  // Failed commands report no append events.
  a_fail_no_events: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != pbt_pkg::STAT_OK)) |->
      !out_key_allocated && !out_copied_on_write && !out_value_allocated)
    else $error("append event on a failed command");

endmodule

bind paged_block_table_refcount pbt_checker u_pbt_checker (.*);

@@ dv/tb_paged_block_table_refcount.sv @@
// ----------------------------------------------------------------------------
// tb_paged_block_table_refcount: self-checking bench for the paged block table
// Drives command transactions through the start/busy handshake and programmes
// the registers between phases. A behavioural copy of the table predicts each
// reply, and every out_valid strobe is checked field by field against the
// oldest prediction. The stimulus runs directed cases, a head filled to its
// block limit, a reference count driven into saturation and three random
// phases with different register settings and sender idling.
// ----------------------------------------------------------------------------
module tb_paged_block_table_refcount;

  localparam int MAX_HEADS   = pbt_pkg::MAX_HEADS_DEF;
  localparam int BLOCK_SLOTS = pbt_pkg::BLOCK_SLOTS_DEF;
  localparam int N_ENTRIES   = MAX_HEADS * BLOCK_SLOTS;

  // Clock, reset and block ports.
  logic                            clk   = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  logic [2:0]                      in_op = '0;
  logic [4:0]                      in_head_index = '0;
  logic [7:0]                      in_block_index = '0;
  logic                            in_value_present = 1'b0;
  logic [10:0]                     in_vector_length = '0;
  logic                            out_valid;
  logic [1:0]                      out_status;
  logic [7:0]                      out_block_used;
  logic                            out_key_allocated;
  logic                            out_copied_on_write;
  logic                            out_value_allocated;
  logic [7:0]                      out_reference_count;
  logic                            out_key_block_present;
  logic                            out_value_block_present;
  logic [3:0]                      out_stored_format;
  logic [23:0]                     out_sequence_length;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pbt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pbt_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the registers.
  logic [pbt_pkg::TPB_W-1:0]  cur_tpb;
  logic [pbt_pkg::BPH_W-1:0]  cur_bph;
  logic [pbt_pkg::HIU_W-1:0]  cur_heads;
  logic [pbt_pkg::VLEN_W-1:0] cur_vlen;
  logic [pbt_pkg::FMT_W-1:0]  cur_fmt;

  // Shadow copy of the head and entry stores.
  logic [pbt_pkg::LEN_W-1:0] tbl_len    [MAX_HEADS];
  logic [pbt_pkg::BPH_W-1:0] tbl_blocks [MAX_HEADS];
  logic [pbt_pkg::RC_W-1:0]  ent_rc     [N_ENTRIES];
  logic                      ent_val    [N_ENTRIES];
  logic [pbt_pkg::FMT_W-1:0] ent_fmt    [N_ENTRIES];

  pbt_pkg::res_t pending_replies[$];
  int   mismatch_count = 0;
  int   idle_pct = 0;

  paged_block_table_refcount u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_op                   (in_op),
    .in_head_index           (in_head_index),
    .in_block_index          (in_block_index),
    .in_value_present        (in_value_present),
    .in_vector_length        (in_vector_length),
    .out_valid               (out_valid),
    .out_status              (out_status),
    .out_block_used          (out_block_used),
    .out_key_allocated       (out_key_allocated),
    .out_copied_on_write     (out_copied_on_write),
    .out_value_allocated     (out_value_allocated),
    .out_reference_count     (out_reference_count),
    .out_key_block_present   (out_key_block_present),
    .out_value_block_present (out_value_block_present),
    .out_stored_format       (out_stored_format),
    .out_sequence_length     (out_sequence_length),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the length of the run.
  initial begin
    #5000000;
    $display("FAIL paged_block_table_refcount");
    $finish;
  end

  // Clears the shadow state to its reset contents.
  task automatic reset_table_model();
    cur_tpb   = pbt_pkg::TPB_RESET;
    cur_bph   = pbt_pkg::BPH_RESET;
    cur_heads = pbt_pkg::HIU_RESET;
    cur_vlen  = pbt_pkg::VLEN_RESET;
    cur_fmt   = pbt_pkg::FMT_RESET;
    for (int h = 0; h < MAX_HEADS; h++) begin
      tbl_len[h]    = '0;
      tbl_blocks[h] = '0;
    end
    for (int i = 0; i < N_ENTRIES; i++) begin
      ent_rc[i]  = '0;
      ent_val[i] = 1'b0;
      ent_fmt[i] = '0;
    end
  endtask

  function automatic int head_limit();
    return (int'(cur_heads) < MAX_HEADS) ? int'(cur_heads) : MAX_HEADS;
  endfunction

  // Works out the reply to one command and applies its effect to the shadow state.
  task automatic compute_table_reply(input logic [2:0] op, input logic [4:0] head,
                                     input logic [7:0] blk, input logic vp,
                                     input logic [10:0] vlen, output pbt_pkg::res_t r);
    int blim;
    int tpb;
    int b;
    int e;
    r = '0;
    r.block_used = blk;
    blim = (int'(cur_bph) < BLOCK_SLOTS) ? int'(cur_bph) : BLOCK_SLOTS;
    if (op > pbt_pkg::OP_READ_LENGTH || int'(head) >= head_limit()) begin
      r.status = pbt_pkg::STAT_BAD;
      return;
    end
    r.sequence_length = tbl_len[head];
    if (op == pbt_pkg::OP_READ_LENGTH) return;

    if (op == pbt_pkg::OP_APPEND) begin
      tpb = (cur_tpb == 0) ? 1 : int'(cur_tpb);
      if (vlen != cur_vlen) begin
        r.status = pbt_pkg::STAT_BAD;
        return;
      end
      b = int'(tbl_len[head]) / tpb;
      if (b >= blim || tbl_len[head] == pbt_pkg::LEN_MAX) begin
        r.status = pbt_pkg::STAT_NO_BLOCKS;
        return;
      end
      e = int'(head) * BLOCK_SLOTS + b;
      // An absent block is allocated; a shared one is copied before the write.
      if (ent_rc[e] == 0) begin
        ent_rc[e]        = pbt_pkg::RC_W'(1);
        ent_fmt[e]       = cur_fmt;
        tbl_blocks[head] = pbt_pkg::BPH_W'(b + 1);
        r.key_allocated  = 1'b1;
      end
      if (ent_rc[e] > 1) begin
        ent_rc[e]         = pbt_pkg::RC_W'(1);
        r.copied_on_write = 1'b1;
      end
      if (vp && !ent_val[e]) begin
        ent_val[e]        = 1'b1;
        r.value_allocated = 1'b1;
      end
      tbl_len[head]     = tbl_len[head] + 1'b1;
      r.block_used      = 8'(b);
      r.sequence_length = tbl_len[head];
    end else begin
      if (int'(blk) >= int'(tbl_blocks[head])) begin
        r.status = pbt_pkg::STAT_BAD;
        return;
      end
      e = int'(head) * BLOCK_SLOTS + int'(blk);
      if (op == pbt_pkg::OP_SHARE) begin
        if (ent_rc[e] == 0) r.status = pbt_pkg::STAT_ABSENT;
        else if (ent_rc[e] != pbt_pkg::RC_MAX) ent_rc[e] = ent_rc[e] + 1'b1;
      end else if (op == pbt_pkg::OP_FREE) begin
        if (ent_rc[e] != 0) ent_rc[e] = ent_rc[e] - 1'b1;
      end
    end
    r.reference_count     = ent_rc[e];
    r.key_block_present   = (ent_rc[e] != 0);
    r.value_block_present = ent_val[e];
    r.stored_format       = ent_fmt[e];
  endtask

  // Sends one command transaction, at idle_pct odds after a random idle gap.
  task automatic send_cmd(input logic [2:0] op, input logic [4:0] head, input logic [7:0] blk,
                          input logic vp, input logic [10:0] vlen);
    pbt_pkg::res_t reply;
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
      repeat ($urandom_range(1, 16)) @(posedge clk);
    start            <= 1'b1;
    in_op            <= op;
    in_head_index    <= head;
    in_block_index   <= blk;
    in_value_present <= vp;
    in_vector_length <= vlen;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    compute_table_reply(op, head, blk, vp, vlen, reply);
    pending_replies.push_back(reply);
  endtask

  // Writes one register through the configuration channel.
  task automatic write_reg(input pbt_pkg::cfg_index_t idx,
                           input logic [pbt_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pbt_pkg::CFG_TOKENS_PER_BLOCK: cur_tpb   = value[pbt_pkg::TPB_W-1:0];
      pbt_pkg::CFG_BLOCKS_PER_HEAD:  cur_bph   = value[pbt_pkg::BPH_W-1:0];
      pbt_pkg::CFG_HEADS_IN_USE:     cur_heads = value[pbt_pkg::HIU_W-1:0];
      pbt_pkg::CFG_VECTOR_LENGTH:    cur_vlen  = value[pbt_pkg::VLEN_W-1:0];
      pbt_pkg::CFG_KEY_FORMAT:       cur_fmt   = value[pbt_pkg::FMT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int tpb, input int bph, input int heads,
                              input int vlen, input int fmt);
    write_reg(pbt_pkg::CFG_TOKENS_PER_BLOCK, pbt_pkg::CFG_DATA_W'(tpb));
    write_reg(pbt_pkg::CFG_BLOCKS_PER_HEAD, pbt_pkg::CFG_DATA_W'(bph));
    write_reg(pbt_pkg::CFG_HEADS_IN_USE, pbt_pkg::CFG_DATA_W'(heads));
    write_reg(pbt_pkg::CFG_VECTOR_LENGTH, pbt_pkg::CFG_DATA_W'(vlen));
    write_reg(pbt_pkg::CFG_KEY_FORMAT, pbt_pkg::CFG_DATA_W'(fmt));
  endtask

  // Holds the sender off until every outstanding reply has arrived.
  task automatic wait_drain();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed commands aimed at heads and blocks in use.
  task automatic send_random_cmd();
    int unsigned pick;
    int nb;
    logic [2:0]  op;
    logic [4:0]  head;
    logic [7:0]  blk;
    logic [10:0] vlen;
    pick = $urandom_range(0, 99);
    if (pick < 42)      op = pbt_pkg::OP_APPEND;
    else if (pick < 62) op = pbt_pkg::OP_SHARE;
    else if (pick < 76) op = pbt_pkg::OP_FREE;
    else if (pick < 89) op = pbt_pkg::OP_READ_ENTRY;
    else if (pick < 96) op = pbt_pkg::OP_READ_LENGTH;
    else                op = 3'($urandom_range(5, 7));
    if (head_limit() > 0 && $urandom_range(0, 9) != 0)
      head = 5'($urandom_range(0, head_limit() - 1));
    else
      head = 5'($urandom);
    nb = int'(tbl_blocks[head]);
    if (nb > 0 && $urandom_range(0, 7) != 0) blk = 8'($urandom_range(0, nb - 1));
    else blk = 8'($urandom);
    if ($urandom_range(0, 9) != 0) vlen = cur_vlen;
    else vlen = 11'($urandom_range(0, 1024));
    send_cmd(op, head, blk, 1'($urandom), vlen);
  endtask

  // Allocation, sharing, copy on write, freeing and the error replies at reset values.
  task automatic test_basic_commands();
    idle_pct = 30;
    send_cmd(pbt_pkg::OP_READ_LENGTH, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b1, 11'd127);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd255, 1'b1, 11'd128);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b0, 11'd128);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_SHARE, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_SHARE, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b1, 11'd128);
    send_cmd(pbt_pkg::OP_FREE, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_FREE, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_SHARE, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b0, 11'd128);
    send_cmd(3'd5, 5'd3, 8'd7, 1'b1, 11'd128);
    send_cmd(3'd6, 5'd0, 8'd0, 1'b0, 11'd0);
    send_cmd(3'd7, 5'd31, 8'd255, 1'b1, 11'd2047);
    send_cmd(pbt_pkg::OP_APPEND, 5'd31, 8'd0, 1'b1, 11'd128);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd31, 8'd255, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_READ_LENGTH, 5'd31, 8'd0, 1'b0, 11'd0);
  endtask

  // Block size 65535 and zero, the smallest other register values, and a limit of 256.
  task automatic test_register_extremes();
    wait_drain();
    apply_config(65535, 1, 1, 1, 0);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b0, 11'd1);
    send_cmd(pbt_pkg::OP_READ_LENGTH, 5'd1, 8'd0, 1'b0, 11'd0);
    wait_drain();
    write_reg(pbt_pkg::CFG_TOKENS_PER_BLOCK, '0);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b1, 11'd1);
    wait_drain();
    write_reg(pbt_pkg::CFG_BLOCKS_PER_HEAD, 16'd256);
    send_cmd(pbt_pkg::OP_APPEND, 5'd0, 8'd0, 1'b1, 11'd1);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd0, 8'd5, 1'b0, 11'd0);
  endtask

  // One head appended one token per block until it runs out of blocks.
  task automatic test_fill_head();
    wait_drain();
    apply_config(1, 511, 40, 1024, 15);
    for (int i = 0; i < 258; i++)
      send_cmd(pbt_pkg::OP_APPEND, 5'd7, 8'($urandom), 1'($urandom), 11'd1024);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd7, 8'd255, 1'b0, 11'd0);
  endtask

  // Shares one entry past the count ceiling, then frees it once.
  task automatic test_count_saturation();
    for (int i = 0; i < 256; i++)
      send_cmd(pbt_pkg::OP_SHARE, 5'd7, 8'd255, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_FREE, 5'd7, 8'd255, 1'b0, 11'd0);
    send_cmd(pbt_pkg::OP_READ_ENTRY, 5'd7, 8'd255, 1'b0, 11'd0);
  endtask

  // Random traffic under one register setting, with a full drain halfway.
  task automatic test_random_traffic(input int idle, input int tpb, input int bph,
                                     input int heads, input int vlen, input int count);
    wait_drain();
    apply_config(tpb, bph, heads, vlen, $urandom_range(0, 15));
    idle_pct = idle;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drain();
      send_random_cmd();
    end
  endtask

  // Each reply strobe is matched against the oldest prediction.
  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pbt_pkg::res_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ERROR reply transaction with nothing outstanding", $time);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 24'(want.status), 24'(out_status));
        check_field("block_used", 24'(want.block_used), 24'(out_block_used));
        check_field("key_allocated", 24'(want.key_allocated), 24'(out_key_allocated));
        check_field("copied_on_write", 24'(want.copied_on_write), 24'(out_copied_on_write));
        check_field("value_allocated", 24'(want.value_allocated), 24'(out_value_allocated));
        check_field("reference_count", 24'(want.reference_count), 24'(out_reference_count));
        check_field("key_block_present", 24'(want.key_block_present),
                    24'(out_key_block_present));
        check_field("value_block_present", 24'(want.value_block_present),
                    24'(out_value_block_present));
        check_field("stored_format", 24'(want.stored_format), 24'(out_stored_format));
        check_field("sequence_length", want.sequence_length, out_sequence_length);
      end
    end
  end

  // Test sequence.
  initial begin
    reset_table_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_register_extremes();
    test_fill_head();
    test_count_saturation();
    test_random_traffic(30, $urandom_range(1, 3), $urandom_range(8, 256), 32,
                        $urandom_range(1, 1024), 400);
    test_random_traffic(77, $urandom_range(1, 8), $urandom_range(1, 64),
                        $urandom_range(4, 32), $urandom_range(1, 1024), 400);
    test_random_traffic(0, 2, 256, 32, 128, 400);
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0)
      $display("PASS paged_block_table_refcount");
    else
      $display("FAIL paged_block_table_refcount");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pbt_pkg.sv
rtl/pbt_cfg.sv
rtl/pbt_div.sv
rtl/paged_block_table_refcount.sv
rtl/pbt_checker.sv
dv/tb_paged_block_table_refcount.sv
